/* rtl/core/mhpq_pkg.sv */
// Shared request/result types and codes for the max-heap priority queue.
package mhpq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [7:0]         count;
  } out_t;

endpackage

/* rtl/core/max_heap_priority_queue.sv */
// Binary max-heap priority queue built around one synchronous key memory.
// Full insert or empty remove answers straight from idle. An insert climbs from the
//   new slot, reading each parent and moving it down while it is smaller than the key;
//   a remove reads the root and the last key, if any, then sifts down past the larger child.
// Requests: one at a time; the block is idle again in the cycle its result is shown.
// Reset: synchronous active-low rst_n empties the heap and clears the strobe.
module max_heap_priority_queue #(
  parameter int HEAP_CAPACITY = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mhpq_pkg::in_t  in_data,
  output logic           out_valid,
  output mhpq_pkg::out_t out_data
);

  localparam int AW = $clog2(HEAP_CAPACITY);
  localparam int CW = $clog2(HEAP_CAPACITY + 1);
  localparam int LW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_RM_LAST, S_RM_KEY, S_DN_RD, S_DN_L, S_DN_R
  } state_t;

  // Key store: one write port, one registered read port.
  logic signed [31:0] mem [HEAP_CAPACITY];
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_data_r;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] lv_r, lv_nxt;
  logic signed [31:0] result_r, result_nxt;
  logic               out_valid_r, out_valid_nxt;
  mhpq_pkg::out_t     out_r, out_nxt;

  logic [AW-1:0]      parent_w;
  logic [LW-1:0]      left_w;
  logic [LW-1:0]      right_w;
  logic [LW-1:0]      count_ext_w;
  logic [31:0]        count32_w;
  logic [31:0]        count32_nxt_w;
  logic               full_w;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign parent_w      = (pos_r - AW'(1)) >> 1;
  assign left_w        = {1'b0, pos_r, 1'b1};
  assign right_w       = left_w + LW'(1);
  assign count_ext_w   = LW'(count_r);
  assign count32_w     = 32'(count_r);
  assign count32_nxt_w = 32'(count_nxt);
  assign full_w        = (count_r >= CW'(HEAP_CAPACITY));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    lv_nxt        = lv_r;
    result_nxt    = result_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = key_r;
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.cmd == mhpq_pkg::CMD_INSERT) begin
            result_nxt = in_data.value;
            if (full_w) begin
              // Drop the request: report full, heap unchanged.
              out_valid_nxt        = 1'b1;
              out_nxt.result_value = in_data.value;
              out_nxt.status       = mhpq_pkg::STATUS_FULL;
              out_nxt.count        = count32_w[7:0];
            end else begin
              key_nxt   = in_data.value;
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt        = 1'b1;
              out_nxt.result_value = '0;
              out_nxt.status       = mhpq_pkg::STATUS_EMPTY;
              out_nxt.count        = count32_w[7:0];
            end else begin
              // Fetch the root; the maximum leaves the heap.
              rd_en     = 1'b1;
              rd_addr   = '0;
              count_nxt = count_r - CW'(1);
              state_nxt = S_RM_LAST;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = parent_w;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_data_r < key_r) begin
          // Move the parent down a level and keep climbing.
          wr_data   = rd_data_r;
          pos_nxt   = parent_w;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_RM_LAST: begin
        result_nxt = rd_data_r;
        if (count_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = count_r[AW-1:0];
          state_nxt = S_RM_KEY;
        end
      end

      S_RM_KEY: begin
        key_nxt   = rd_data_r;
        pos_nxt   = '0;
        state_nxt = S_DN_RD;
      end

      S_DN_RD: begin
        if (left_w >= count_ext_w) begin
          wr_en     = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = left_w[AW-1:0];
          state_nxt = S_DN_L;
        end
      end

      S_DN_L: begin
        lv_nxt = rd_data_r;
        if (right_w < count_ext_w) begin
          rd_en     = 1'b1;
          rd_addr   = right_w[AW-1:0];
          state_nxt = S_DN_R;
        end else begin
          wr_en = 1'b1;
          if (rd_data_r > key_r) begin
            wr_data   = rd_data_r;
            pos_nxt   = left_w[AW-1:0];
            state_nxt = S_DN_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_DN_R: begin
        wr_en = 1'b1;
        // Take the larger child; ties go left.
        if (rd_data_r > lv_r) begin
          if (rd_data_r > key_r) begin
            wr_data   = rd_data_r;
            pos_nxt   = right_w[AW-1:0];
            state_nxt = S_DN_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          if (lv_r > key_r) begin
            wr_data   = lv_r;
            pos_nxt   = left_w[AW-1:0];
            state_nxt = S_DN_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Completion of a request posts the registered result in the next cycle.
    if (state_r != S_IDLE && state_nxt == S_IDLE) begin
      out_valid_nxt        = 1'b1;
      out_nxt.result_value = result_nxt;
      out_nxt.status       = mhpq_pkg::STATUS_OK;
      out_nxt.count        = count32_nxt_w[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    lv_r     <= lv_nxt;
    result_r <= result_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/core/mhpq_checker.sv */
// Port-level checks for the max-heap priority queue, bound to the top level.
module mhpq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input mhpq_pkg::in_t  in_data,
  input logic           out_valid,
  input mhpq_pkg::out_t out_data
);

  // An accepted request either posts its result or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request made no progress");

  // A full-heap insert echoes the offered value on the next cycle.
  a_full_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.cmd == mhpq_pkg::CMD_INSERT) ##1
      (out_valid && out_data.status == mhpq_pkg::STATUS_FULL)
      |-> out_data.result_value == $past(in_data.value))
    else $error("full insert did not echo value");

  // An empty remove reports zero value and zero count.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == mhpq_pkg::STATUS_EMPTY)
      |-> (out_data.count == 8'd0 && out_data.result_value == 32'sd0))
    else $error("empty remove result malformed");

  // A status code is never the unused one.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == mhpq_pkg::STATUS_OK ||
                   out_data.status == mhpq_pkg::STATUS_FULL ||
                   out_data.status == mhpq_pkg::STATUS_EMPTY))
    else $error("bad status code");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
